[design/map_polyline_projector_unit_macros.svh]
// Assertion helpers for the projector top level.
`ifndef MAP_POLYLINE_PROJECTOR_UNIT_MACROS_SVH
`define MAP_POLYLINE_PROJECTOR_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MPP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mpp_pkg.sv]
`default_nettype none
package mpp_pkg;

  typedef struct packed {
    logic signed [15:0] record_code;
    logic signed [15:0] lat_minutes;
    logic signed [15:0] long_minutes;
  } item_t;

  typedef struct packed {
    logic               draw;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
  } result_t;

  typedef struct packed {
    logic signed [14:0] origin_long;
    logic signed [13:0] origin_lat;
    logic [31:0]        x_scale;
    logic [31:0]        y_scale;
    logic [12:0]        map_width;
    logic [12:0]        map_height;
  } cfg_t;

  // Load enables of the pipeline stages.
  typedef struct packed {
    logic diff;
    logic mul;
    logic round;
    logic seg;
  } stage_en_t;

  // Projected point handed from the projection stages to the segment stage.
  typedef struct packed {
    logic               skip;
    logic               start;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_LONG = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_LAT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_X_SCALE     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_SCALE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT  = 3'd5;

  localparam logic signed [14:0] RST_ORIGIN_LONG = -15'sd10800;
  localparam logic signed [13:0] RST_ORIGIN_LAT  = -14'sd5400;
  localparam logic [31:0]        RST_X_SCALE     = 32'd16777216;
  localparam logic [31:0]        RST_Y_SCALE     = 32'd16777216;
  localparam logic [12:0]        RST_MAP_WIDTH   = 13'd640;
  localparam logic [12:0]        RST_MAP_HEIGHT  = 13'd480;

  localparam logic signed [15:0] WRAP_HIGH = 16'sd10800;
  localparam logic signed [15:0] WRAP_LOW  = -16'sd10800;
  localparam logic signed [15:0] WRAP_SPAN = 16'sd21600;

  localparam logic signed [15:0] CLASS_7000 = 16'sd7000;
  localparam logic signed [15:0] CLASS_5000 = 16'sd5000;
  localparam logic signed [15:0] CLASS_3000 = 16'sd3000;
  localparam logic signed [15:0] CLASS_1000 = 16'sd1000;

  localparam int LONG_DIFF_W = 16;
  localparam int LAT_DIFF_W  = 17;
  localparam int PROD_W      = 51;
  localparam int FRAC_W      = 24;
  localparam int ROUND_W     = PROD_W - FRAC_W;
  localparam int WIDE_W      = ROUND_W + 1;

  localparam logic signed [PROD_W-1:0] HALF_Q24 = 51'sd8388608;
  localparam logic [16:0]              JUMP_Y_LIMIT = 17'd50;

endpackage
`default_nettype wire

[design/mpp_cfg_regs.sv]
`default_nettype none
module mpp_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic [mpp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [mpp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output mpp_pkg::cfg_t                        cfg
);
  import mpp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_long <= RST_ORIGIN_LONG;
      cfg.origin_lat  <= RST_ORIGIN_LAT;
      cfg.x_scale     <= RST_X_SCALE;
      cfg.y_scale     <= RST_Y_SCALE;
      cfg.map_width   <= RST_MAP_WIDTH;
      cfg.map_height  <= RST_MAP_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_LONG: cfg.origin_long <= $signed(cfg_data[14:0]);
        REG_ORIGIN_LAT:  cfg.origin_lat  <= $signed(cfg_data[13:0]);
        REG_X_SCALE:     cfg.x_scale     <= cfg_data;
        REG_Y_SCALE:     cfg.y_scale     <= cfg_data;
        REG_MAP_WIDTH:   cfg.map_width   <= cfg_data[12:0];
        REG_MAP_HEIGHT:  cfg.map_height  <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[design/mpp_project.sv]
`default_nettype none
module mpp_project (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mpp_pkg::stage_en_t en,
  input  wire mpp_pkg::item_t     item,
  input  wire mpp_pkg::cfg_t      cfg,
  output mpp_pkg::point_t         point
);
  import mpp_pkg::*;

  function automatic logic signed [15:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [15:0] r;
    if (v > $signed(WIDE_W'(32767))) r = 16'sh7FFF;
    else if (v < -$signed(WIDE_W'(32768))) r = -16'sd32768;
    else r = v[15:0];
    return r;
  endfunction

  // Stage one: class update, longitude wrap and origin offsets.
  logic                          skip_flag;
  logic                          skip_next;
  logic signed [15:0]            lon_a;
  logic signed [15:0]            lon_b;
  logic signed [LONG_DIFF_W-1:0] dlon_next;
  logic signed [LAT_DIFF_W-1:0]  dlat_next;

  logic                          s1_skip;
  logic                          s1_start;
  logic signed [LONG_DIFF_W-1:0] s1_dlon;
  logic signed [LAT_DIFF_W-1:0]  s1_dlat;

  always_comb begin
    skip_next = skip_flag;
    if (item.record_code >= CLASS_7000) skip_next = 1'b1;
    else if (item.record_code >= CLASS_5000) skip_next = 1'b0;
    else if (item.record_code >= CLASS_3000) skip_next = 1'b1;
    else if (item.record_code >= CLASS_1000) skip_next = 1'b0;

    lon_a = (item.long_minutes > WRAP_HIGH) ? item.long_minutes - WRAP_SPAN
                                            : item.long_minutes;
    lon_b = (lon_a < WRAP_LOW) ? lon_a + WRAP_SPAN : lon_a;

    dlon_next = lon_b - $signed({cfg.origin_long[14], cfg.origin_long});
    dlat_next = $signed({item.lat_minutes[15], item.lat_minutes})
              - $signed({{3{cfg.origin_lat[13]}}, cfg.origin_lat});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_flag <= 1'b0;
    end else if (en.diff) begin
      skip_flag <= skip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en.diff) begin
      s1_skip  <= skip_next;
      s1_start <= (item.record_code >= CLASS_1000);
      s1_dlon  <= dlon_next;
      s1_dlat  <= dlat_next;
    end
  end

  // Stage two: Q8.24 scaling plus one half.
  logic                     s2_skip;
  logic                     s2_start;
  logic signed [PROD_W-1:0] s2_px;
  logic signed [PROD_W-1:0] s2_py;
  logic signed [PROD_W-1:0] px_next;
  logic signed [PROD_W-1:0] py_next;

  always_comb begin
    px_next = $signed({1'b0, cfg.x_scale}) * s1_dlon + HALF_Q24;
    py_next = $signed({1'b0, cfg.y_scale}) * s1_dlat + HALF_Q24;
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      s2_skip  <= s1_skip;
      s2_start <= s1_start;
      s2_px    <= px_next;
      s2_py    <= py_next;
    end
  end

  // Stage three: truncate toward zero, flip y, saturate.
  // A negative value with a nonzero fraction is one above its floor.
  logic signed [ROUND_W-1:0] rx;
  logic signed [ROUND_W-1:0] ry;
  logic signed [WIDE_W-1:0]  y_wide;

  always_comb begin
    rx = $signed(s2_px[PROD_W-1:FRAC_W])
       + $signed({{(ROUND_W-1){1'b0}}, s2_px[PROD_W-1] & (|s2_px[FRAC_W-1:0])});
    ry = $signed(s2_py[PROD_W-1:FRAC_W])
       + $signed({{(ROUND_W-1){1'b0}}, s2_py[PROD_W-1] & (|s2_py[FRAC_W-1:0])});
    y_wide = $signed({{(WIDE_W-13){1'b0}}, cfg.map_height}) - $signed({ry[ROUND_W-1], ry});
  end

  always_ff @(posedge clk) begin
    if (en.round) begin
      point.skip  <= s2_skip;
      point.start <= s2_start;
      point.x     <= sat16($signed({rx[ROUND_W-1], rx}));
      point.y     <= sat16(y_wide);
    end
  end

endmodule
`default_nettype wire

[design/mpp_segment.sv]
`default_nettype none
module mpp_segment (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire mpp_pkg::point_t point,
  input  wire mpp_pkg::cfg_t   cfg,
  output mpp_pkg::result_t     result
);
  import mpp_pkg::*;

  function automatic logic on_screen(input logic signed [15:0] x,
                                     input logic signed [15:0] y,
                                     input logic [12:0]        w,
                                     input logic [12:0]        h);
    logic ok;
    ok = !x[15] && (x[14:0] < {2'b00, w}) && !y[15] && (y[14:0] < {2'b00, h});
    return ok;
  endfunction

  logic signed [15:0] prev_x;
  logic signed [15:0] prev_y;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [16:0]        adx;
  logic [16:0]        ady;
  logic               draw;
  result_t            result_next;

  always_comb begin
    dx  = $signed({prev_x[15], prev_x}) - $signed({point.x[15], point.x});
    dy  = $signed({prev_y[15], prev_y}) - $signed({point.y[15], point.y});
    adx = dx[16] ? 17'(-dx) : 17'(dx);
    ady = dy[16] ? 17'(-dy) : 17'(dy);

    draw = !point.skip && !point.start
        && (adx <= {5'b0, cfg.map_width[12:1]})
        && (ady <= JUMP_Y_LIMIT)
        && (on_screen(prev_x, prev_y, cfg.map_width, cfg.map_height)
            || on_screen(point.x, point.y, cfg.map_width, cfg.map_height));

    result_next = '0;
    if (draw) begin
      result_next.draw   = 1'b1;
      result_next.from_x = prev_x;
      result_next.from_y = prev_y;
      result_next.to_x   = point.x;
      result_next.to_y   = point.y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else if (en && !point.skip) begin
      prev_x <= point.x;
      prev_y <= point.y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

[design/map_polyline_projector_unit.sv]
// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_ready   item_t: record_code, lat_minutes, long_minutes
// result    out        result_valid/result_ready result_t: draw, from_x, from_y, to_x, to_y
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data (always ready)
//
// One result per item; four register stages (offsets, multiply, round, segment) give
// a sustained rate of one item per cycle while the result channel is not stalled.
// The multiply stage sets the clock; the previous-point loop is one stage deep.
// Synchronous reset clears valid bits, skip flag and previous point and loads the config defaults.
// A stalled result holds the last stage; bubbles further up still take items.
`default_nettype none
module map_polyline_projector_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_ready,
  input  wire mpp_pkg::item_t                 item,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output mpp_pkg::result_t                    result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mpp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [mpp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mpp_pkg::*;

  cfg_t      cfg;
  stage_en_t en;
  point_t    point;

  logic v1;
  logic v2;
  logic v3;
  logic ready1;
  logic ready2;
  logic ready3;
  logic ready4;

  assign cfg_ready = 1'b1;

  // A stage can load when it is empty or its content moves on this cycle.
  always_comb begin
    ready4     = !result_valid || result_ready;
    ready3     = !v3 || ready4;
    ready2     = !v2 || ready3;
    ready1     = !v1 || ready2;
    item_ready = ready1;

    en.diff  = item_valid && ready1;
    en.mul   = v1 && ready2;
    en.round = v2 && ready3;
    en.seg   = v3 && ready4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      v1           <= en.diff  || (v1 && !ready2);
      v2           <= en.mul   || (v2 && !ready3);
      v3           <= en.round || (v3 && !ready4);
      result_valid <= en.seg   || (result_valid && !result_ready);
    end
  end

  mpp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mpp_project u_project (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .item  (item),
    .cfg   (cfg),
    .point (point)
  );

  mpp_segment u_segment (
    .clk    (clk),
    .rst    (rst),
    .en     (en.seg),
    .point  (point),
    .cfg    (cfg),
    .result (result)
  );

`include "map_polyline_projector_unit_macros.svh"

  `MPP_ASSERT_NOW(a_nodraw_zero, clk, rst, result_valid && !result.draw,
    (result.from_x == 16'sd0) && (result.from_y == 16'sd0) &&
    (result.to_x == 16'sd0) && (result.to_y == 16'sd0),
    "result without a segment carries nonzero coordinates")
  `MPP_ASSERT_NOW(a_backpressure_full, clk, rst, !item_ready,
    v1 && v2 && v3 && result_valid,
    "item channel stalled while the pipeline has a free stage")
  `MPP_ASSERT_NEXT(a_stage3_held, clk, rst, v3 && !ready4, v3,
    "round stage dropped an item while the output was stalled")

endmodule
`default_nettype wire
